// File: rtl/core/cfnac_pkg.sv
// ----------------------------------------------------------------------------
// cfnac_pkg
// Shared types, constants and helpers of the cube-face normal attribute codec.
// ----------------------------------------------------------------------------
package cfnac_pkg;

  localparam int unsigned U_BITS_DEF     = 14;
  localparam int unsigned V_BITS_DEF     = 13;
  localparam int unsigned COMP_WIDTH_DEF = 16;
  localparam int unsigned U_BITS_MAX     = 15;
  localparam int unsigned V_BITS_MAX     = 14;

  // signed face-vector component, wide enough for the largest U/V setting
  localparam int unsigned VEC_W = U_BITS_MAX + V_BITS_MAX + 1;

  localparam int unsigned QUEUE_DEPTH = 2;

  // Q1.15 normalization: quotient bits and fraction bits
  localparam int unsigned NORM_QBITS = 16;
  localparam int unsigned NORM_FRAC  = 15;
  localparam logic [15:0] NORM_SAT   = 16'h7FFF;
  localparam logic [7:0]  BYTE_MAX   = 8'hFF;

  typedef enum logic {
    MODE_ENCODE = 1'b0,
    MODE_DECODE = 1'b1
  } mode_e;

  typedef enum logic [1:0] {
    AXIS_X   = 2'd0,
    AXIS_Y   = 2'd1,
    AXIS_Z   = 2'd2,
    AXIS_BAD = 2'd3
  } axis_e;

  typedef struct packed {
    logic               mode;
    logic signed [15:0] normal_x_in;
    logic signed [15:0] normal_y_in;
    logic signed [15:0] normal_z_in;
    logic signed [15:0] red_in;
    logic signed [15:0] green_in;
    logic signed [15:0] blue_in;
    logic [2:0]         face_code_in;
    logic [13:0]        u_code_in;
    logic [12:0]        v_code_in;
  } cfnac_in_t;

  typedef struct packed {
    logic [2:0]         face_code_out;
    logic [13:0]        u_code_out;
    logic [12:0]        v_code_out;
    logic [7:0]         red_out;
    logic [7:0]         green_out;
    logic [7:0]         blue_out;
    logic [7:0]         alpha_out;
    logic signed [15:0] normal_x_out;
    logic signed [15:0] normal_y_out;
    logic signed [15:0] normal_z_out;
    logic               face_error;
  } cfnac_out_t;

  // Classified request. Encode: c0 = dominant magnitude, c1/c2 = face comps.
  // Decode: c0..c2 = unnormalized face vector.
  typedef struct packed {
    logic                    dec;
    logic                    err;
    logic                    zero;
    logic [2:0]              face;
    logic [7:0]              red;
    logic [7:0]              green;
    logic [7:0]              blue;
    logic signed [VEC_W-1:0] c0;
    logic signed [VEC_W-1:0] c1;
    logic signed [VEC_W-1:0] c2;
  } cfnac_item_t;

  // Q4.12 channel to saturated byte: (c * 255) >> 12, clamped
  function automatic logic [7:0] color_byte(input logic signed [15:0] c);
    logic [23:0] prod;
    logic [11:0] q;
    begin
      prod = ({9'd0, c[14:0]} << 8) - {9'd0, c[14:0]};
      q    = prod[23:12];
      if (c[15]) begin
        color_byte = '0;
      end else if (q > 12'(BYTE_MAX)) begin
        color_byte = BYTE_MAX;
      end else begin
        color_byte = q[7:0];
      end
    end
  endfunction

endpackage

// File: rtl/core/cfnac_front.sv
// ----------------------------------------------------------------------------
// cfnac_front
// Accepts requests, picks the dominant axis (encode) or builds the face vector
// (decode), and on encode converts the color channels. One register stage.
// ----------------------------------------------------------------------------
module cfnac_front import cfnac_pkg::*; #(
  parameter int unsigned U_BITS     = U_BITS_DEF,
  parameter int unsigned V_BITS     = V_BITS_DEF,
  parameter int unsigned COMP_WIDTH = COMP_WIDTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  cfnac_in_t   in_req_i,
  output logic        item_valid_o,
  input  logic        item_ready_i,
  output cfnac_item_t item_o
);

  localparam int unsigned CW = COMP_WIDTH;
  localparam int unsigned MW = U_BITS + V_BITS;
  localparam logic [U_BITS-1:0] UMAX  = '1;
  localparam logic [V_BITS-1:0] VMAX  = '1;
  localparam logic [MW-1:0]     MAJOR = MW'(UMAX) * MW'(VMAX);

  logic               valid_q;
  cfnac_item_t        item_q, item_d;

  logic signed [CW:0] nx, ny, nz, ea, eb;
  logic [CW:0]        ax, ay, az, m;
  axis_e              eaxis, daxis;
  logic               eneg;

  logic [U_BITS-1:0]           uc;
  logic [V_BITS-1:0]           vc;
  logic signed [U_BITS+1:0]    tu;
  logic signed [V_BITS+1:0]    tv;
  logic signed [MW+2:0]        uu, vv;
  logic signed [VEC_W-1:0]     major;

  assign in_ready_o   = !valid_q || item_ready_i;
  assign item_valid_o = valid_q;
  assign item_o       = item_q;

  always_comb begin
    // low COMP_WIDTH bits, read as two's complement
    nx = (CW+1)'(signed'(CW'($unsigned(in_req_i.normal_x_in))));
    ny = (CW+1)'(signed'(CW'($unsigned(in_req_i.normal_y_in))));
    nz = (CW+1)'(signed'(CW'($unsigned(in_req_i.normal_z_in))));
    ax = nx[CW] ? $unsigned(-nx) : $unsigned(nx);
    ay = ny[CW] ? $unsigned(-ny) : $unsigned(ny);
    az = nz[CW] ? $unsigned(-nz) : $unsigned(nz);

    // ties go to X, then Y
    if (ax >= ay && ax >= az) begin
      eaxis = AXIS_X; m = ax; ea = ny; eb = nz; eneg = nx[CW];
    end else if (ay >= az) begin
      eaxis = AXIS_Y; m = ay; ea = nx; eb = nz; eneg = ny[CW];
    end else begin
      eaxis = AXIS_Z; m = az; ea = nx; eb = ny; eneg = nz[CW];
    end

    uc    = U_BITS'(in_req_i.u_code_in);
    vc    = V_BITS'(in_req_i.v_code_in);
    tu    = signed'({1'b0, uc, 1'b0}) - signed'({2'b00, UMAX});
    tv    = signed'({1'b0, vc, 1'b0}) - signed'({2'b00, VMAX});
    uu    = tu * signed'({1'b0, VMAX});
    vv    = tv * signed'({1'b0, UMAX});
    major = VEC_W'(signed'({1'b0, MAJOR}));
    if (in_req_i.face_code_in[0]) begin
      major = -major;
    end
    daxis = axis_e'(in_req_i.face_code_in[2:1]);

    item_d = '0;
    if (in_req_i.mode == MODE_DECODE) begin
      item_d.dec = 1'b1;
      case (daxis)
        AXIS_X: begin
          item_d.c0 = major; item_d.c1 = VEC_W'(uu); item_d.c2 = VEC_W'(vv);
        end
        AXIS_Y: begin
          item_d.c0 = VEC_W'(uu); item_d.c1 = major; item_d.c2 = VEC_W'(vv);
        end
        AXIS_Z: begin
          item_d.c0 = VEC_W'(uu); item_d.c1 = VEC_W'(vv); item_d.c2 = major;
        end
        default: begin
          item_d.err = 1'b1;
        end
      endcase
    end else begin
      item_d.face  = {eaxis, eneg};
      item_d.zero  = (m == '0);
      item_d.red   = color_byte(in_req_i.red_in);
      item_d.green = color_byte(in_req_i.green_in);
      item_d.blue  = color_byte(in_req_i.blue_in);
      item_d.c0    = VEC_W'(m);
      item_d.c1    = VEC_W'(ea);
      item_d.c2    = VEC_W'(eb);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= item_d;
    end
  end

endmodule

// File: rtl/core/cfnac_queue.sv
// ----------------------------------------------------------------------------
// cfnac_queue
// Short FIFO between the classify front and the arithmetic back.
// ----------------------------------------------------------------------------
module cfnac_queue import cfnac_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  cfnac_item_t item_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output cfnac_item_t item_o
);

  localparam int unsigned PW   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNTW = $clog2(QUEUE_DEPTH + 1);

  cfnac_item_t     mem_q [QUEUE_DEPTH];
  logic [PW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CNTW-1:0] count_q;
  logic            push, pop;

  assign in_ready_o  = (count_q != CNTW'(QUEUE_DEPTH));
  assign out_valid_o = (count_q != '0);
  assign item_o      = mem_q[rd_ptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

// File: rtl/core/cfnac_back.sv
// ----------------------------------------------------------------------------
// cfnac_back
// Arithmetic pipeline: squares, sum, bit-per-stage square root, three restoring
// dividers (one per component), then result formatting into the output register.
// ----------------------------------------------------------------------------
module cfnac_back import cfnac_pkg::*; #(
  parameter int unsigned U_BITS     = U_BITS_DEF,
  parameter int unsigned V_BITS     = V_BITS_DEF,
  parameter int unsigned COMP_WIDTH = COMP_WIDTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        item_valid_i,
  output logic        item_ready_o,
  input  cfnac_item_t item_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output cfnac_out_t  out_rsp_o
);

  localparam int unsigned MW   = U_BITS + V_BITS;
  localparam int unsigned LW   = MW + 1;
  localparam int unsigned SW   = 2 * MW + 2;
  localparam int unsigned CW   = COMP_WIDTH;
  localparam int unsigned DENW = (LW > CW + 1) ? LW : CW + 1;
  localparam int unsigned QB   = NORM_QBITS;
  localparam int unsigned NUMW = DENW + QB;
  localparam logic [U_BITS-1:0] UMAX    = '1;
  localparam logic [V_BITS-1:0] VMAX    = '1;
  localparam logic [U_BITS-1:0] UCENTER = {1'b1, (U_BITS-1)'(0)};
  localparam logic [V_BITS-1:0] VCENTER = {1'b1, (V_BITS-1)'(0)};

  typedef struct packed {
    logic       dec;
    logic       err;
    logic       zero;
    logic [2:0] face;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [2:0] neg;
  } tag_t;

  function automatic logic [15:0] norm_out(input logic [QB-1:0] q, input logic neg);
    logic [15:0] sat;
    begin
      sat      = (16'(q) > NORM_SAT) ? NORM_SAT : 16'(q);
      norm_out = neg ? -sat : sat;
    end
  endfunction

  logic       en;
  logic       out_valid_q;
  cfnac_out_t out_q, out_d;

  // whole pipe advances unless the output register is held
  assign en           = !out_valid_q || out_ready_i;
  assign item_ready_o = en;
  assign out_valid_o  = out_valid_q;
  assign out_rsp_o    = out_q;

  // ---- squares ----
  logic signed [VEC_W-1:0] in_comp [3];
  logic [MW-1:0]           in_mag  [3];
  logic                    sq_valid_q;
  cfnac_item_t             sq_item_q;
  logic [2*MW-1:0]         sq_q [3];

  assign in_comp[0] = item_i.c0;
  assign in_comp[1] = item_i.c1;
  assign in_comp[2] = item_i.c2;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      in_mag[k] = in_comp[k][VEC_W-1] ? MW'(-in_comp[k]) : MW'(in_comp[k]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sq_item_q <= item_i;
      for (int k = 0; k < 3; k++) begin
        sq_q[k] <= (2*MW)'(in_mag[k]) * (2*MW)'(in_mag[k]);
      end
    end
  end

  // ---- sum (index 0) and square root, one result bit per stage ----
  logic [LW:0]     rt_valid_q;
  cfnac_item_t     rt_item_q [LW+1];
  logic [SW-1:0]   rt_rem_q  [LW+1];
  logic [LW-1:0]   rt_root_q [LW+1];

  always_ff @(posedge clk_i) begin
    if (en) begin
      rt_item_q[0] <= sq_item_q;
      rt_rem_q[0]  <= SW'(sq_q[0]) + SW'(sq_q[1]) + SW'(sq_q[2]);
      rt_root_q[0] <= '0;
    end
  end

  for (genvar k = 1; k <= LW; k++) begin : g_sqrt
    localparam int unsigned BI = LW - k;
    logic [SW-1:0] trial;
    logic          ge;

    always_comb begin
      trial = (SW'(rt_root_q[k-1]) << (BI + 1)) | (SW'(1) << (2 * BI));
      ge    = (rt_rem_q[k-1] >= trial);
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        rt_item_q[k] <= rt_item_q[k-1];
        rt_rem_q[k]  <= ge ? rt_rem_q[k-1] - trial : rt_rem_q[k-1];
        rt_root_q[k] <= rt_root_q[k-1] | (ge ? (LW'(1) << BI) : '0);
      end
    end
  end

  // ---- divider setup (index 0) and restoring division ----
  logic [QB:0]       dv_valid_q;
  tag_t              dv_tag_q [QB+1];
  logic [DENW-1:0]   dv_r_q   [QB+1][3];
  logic [DENW-1:0]   dv_d_q   [QB+1][3];
  logic [QB-1:0]     dv_n_q   [QB+1][3];
  logic [QB-1:0]     dv_qt_q  [QB+1][3];

  cfnac_item_t             pit;
  logic [LW-1:0]           plen;
  logic signed [VEC_W-1:0] pcomp [3];
  logic [MW-1:0]           pmag  [3];
  logic [CW:0]             pm;
  logic [CW+1:0]           apm_u, apm_v;
  logic [NUMW-1:0]         pnum  [3];
  logic [DENW-1:0]         pden  [3];
  tag_t                    ptag;

  assign pit      = rt_item_q[LW];
  assign plen     = rt_root_q[LW];
  assign pcomp[0] = pit.c0;
  assign pcomp[1] = pit.c1;
  assign pcomp[2] = pit.c2;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      pmag[k] = pcomp[k][VEC_W-1] ? MW'(-pcomp[k]) : MW'(pcomp[k]);
    end
    pm    = pcomp[0][CW:0];
    apm_u = pcomp[1][CW+1:0] + pcomp[0][CW+1:0];
    apm_v = pcomp[2][CW+1:0] + pcomp[0][CW+1:0];

    ptag.dec   = pit.dec;
    ptag.err   = pit.err;
    ptag.zero  = pit.zero;
    ptag.face  = pit.face;
    ptag.red   = pit.red;
    ptag.green = pit.green;
    ptag.blue  = pit.blue;
    ptag.neg   = {pcomp[2][VEC_W-1], pcomp[1][VEC_W-1], pcomp[0][VEC_W-1]};

    if (pit.dec) begin
      // (|c| * 2^15 + L/2) / L
      for (int k = 0; k < 3; k++) begin
        pnum[k] = (NUMW'(pmag[k]) << NORM_FRAC) + NUMW'(plen >> 1);
        pden[k] = DENW'(plen);
      end
    end else begin
      // ((a + m) * max + m) / (2m)
      pnum[0] = NUMW'(apm_u[CW:0]) * NUMW'(UMAX) + NUMW'(pm);
      pnum[1] = NUMW'(apm_v[CW:0]) * NUMW'(VMAX) + NUMW'(pm);
      pnum[2] = '0;
      pden[0] = DENW'({pm, 1'b0});
      pden[1] = DENW'({pm, 1'b0});
      pden[2] = DENW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dv_tag_q[0] <= ptag;
      for (int l = 0; l < 3; l++) begin
        dv_r_q[0][l]  <= DENW'(pnum[l] >> QB);
        dv_n_q[0][l]  <= pnum[l][QB-1:0];
        dv_d_q[0][l]  <= pden[l];
        dv_qt_q[0][l] <= '0;
      end
    end
  end

  for (genvar k = 1; k <= QB; k++) begin : g_div
    always_ff @(posedge clk_i) begin
      if (en) begin
        dv_tag_q[k] <= dv_tag_q[k-1];
      end
    end

    for (genvar l = 0; l < 3; l++) begin : g_lane
      logic [DENW:0] r2;
      logic          ge;

      always_comb begin
        r2 = {dv_r_q[k-1][l], dv_n_q[k-1][l][QB-1]};
        ge = (r2 >= {1'b0, dv_d_q[k-1][l]});
      end

      always_ff @(posedge clk_i) begin
        if (en) begin
          dv_r_q[k][l]  <= ge ? DENW'(r2 - {1'b0, dv_d_q[k-1][l]}) : DENW'(r2);
          dv_n_q[k][l]  <= dv_n_q[k-1][l] << 1;
          dv_d_q[k][l]  <= dv_d_q[k-1][l];
          dv_qt_q[k][l] <= {dv_qt_q[k-1][l][QB-2:0], ge};
        end
      end
    end
  end

  // ---- result formatting ----
  tag_t          ot;
  logic [QB-1:0] oq [3];

  assign ot    = dv_tag_q[QB];
  assign oq[0] = dv_qt_q[QB][0];
  assign oq[1] = dv_qt_q[QB][1];
  assign oq[2] = dv_qt_q[QB][2];

  always_comb begin
    out_d = '0;
    if (!ot.dec) begin
      out_d.face_code_out = ot.face;
      out_d.u_code_out    = ot.zero ? 14'(UCENTER) : 14'(oq[0][U_BITS-1:0]);
      out_d.v_code_out    = ot.zero ? 13'(VCENTER) : 13'(oq[1][V_BITS-1:0]);
      out_d.red_out       = ot.red;
      out_d.green_out     = ot.green;
      out_d.blue_out      = ot.blue;
      out_d.alpha_out     = BYTE_MAX;
    end else if (ot.err) begin
      out_d.face_error = 1'b1;
    end else begin
      out_d.normal_x_out = signed'(norm_out(oq[0], ot.neg[0]));
      out_d.normal_y_out = signed'(norm_out(oq[1], ot.neg[1]));
      out_d.normal_z_out = signed'(norm_out(oq[2], ot.neg[2]));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_valid_q  <= 1'b0;
      rt_valid_q  <= '0;
      dv_valid_q  <= '0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      sq_valid_q  <= item_valid_i;
      rt_valid_q  <= {rt_valid_q[LW-1:0], sq_valid_q};
      dv_valid_q  <= {dv_valid_q[QB-1:0], rt_valid_q[LW]};
      out_valid_q <= dv_valid_q[QB];
    end
  end

endmodule

// File: rtl/core/cube_face_normal_attr_codec.sv
// Pipeline: front register, queue, squares, sum, square root and divider
// stages, then the output register.
// Throughput: one request per cycle; stalls only when the output is held.
// Reset: asynchronous active-low; clears all valid flags and queue pointers,
// no clearing pass, ready right after reset.
// ----------------------------------------------------------------------------
// cube_face_normal_attr_codec
// Cube-face normal and color attribute codec, encode and decode per request.
// ----------------------------------------------------------------------------
module cube_face_normal_attr_codec import cfnac_pkg::*; #(
  parameter int unsigned U_BITS     = U_BITS_DEF,
  parameter int unsigned V_BITS     = V_BITS_DEF,
  parameter int unsigned COMP_WIDTH = COMP_WIDTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  cfnac_in_t  in_req_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output cfnac_out_t out_rsp_o
);

  logic        fr_valid, fr_ready;
  cfnac_item_t fr_item;
  logic        qu_valid, qu_ready;
  cfnac_item_t qu_item;

  cfnac_front #(
    .U_BITS    (U_BITS),
    .V_BITS    (V_BITS),
    .COMP_WIDTH(COMP_WIDTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .item_valid_o(fr_valid),
    .item_ready_i(fr_ready),
    .item_o      (fr_item)
  );

  cfnac_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (fr_valid),
    .in_ready_o (fr_ready),
    .item_i     (fr_item),
    .out_valid_o(qu_valid),
    .out_ready_i(qu_ready),
    .item_o     (qu_item)
  );

  cfnac_back #(
    .U_BITS    (U_BITS),
    .V_BITS    (V_BITS),
    .COMP_WIDTH(COMP_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_valid_i(qu_valid),
    .item_ready_o(qu_ready),
    .item_i      (qu_item),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o)
  );

endmodule
